[hw/rtl/text_console_cursor_engine_top_macros.svh]
// Assertion macros shared by the console engine modules.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TCE_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TCE_ASSERT(label, clk, rst_n, prop)
`define TCE_ASSERT_NR(label, clk, prop)
`endif
`endif

[hw/rtl/tce_pkg.sv]
`timescale 1ns / 1ps
package tce_pkg;
  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 128;
  localparam int unsigned CellW = 16;

  localparam logic [1:0] CmdPut   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdSet   = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic [1:0] CfgRows = 2'd0;
  localparam logic [1:0] CfgCols = 2'd1;
  localparam logic [1:0] CfgAttr = 2'd2;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChRight = 8'h91;
  localparam logic [7:0] ChUp    = 8'h90;
  localparam logic [7:0] ChLeft  = 8'h93;
  localparam logic [7:0] ChDown  = 8'h92;
  localparam logic [7:0] ChHome  = 8'h94;
  localparam logic [7:0] ChDel   = 8'h99;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,      // idle
    OpLoad,      // take the item, clamp the cursor
    OpWrite,     // write cell at cursor (char or blank)
    OpAdvance,   // step cursor after a store
    OpCtrl,      // simple cursor move for control codes
    OpBsLeft,    // step column left before delete
    OpRdStart,   // issue read for a target cell
    OpRdDone,    // capture read data
    OpSetCur,    // set cursor to target
    OpSeqInit,   // start a memory walk
    OpSeqRead,   // read source of a walk step
    OpSeqWrite,  // write destination of a walk step
    OpFinish     // present result
  } op_e;

  typedef enum logic [1:0] {
    WalkClear,
    WalkScroll,
    WalkDelete
  } walk_e;

  typedef struct packed {
    op_e   op;
    walk_e walk;
    logic  blank;  // write a blank instead of the item char
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic       wrap;       // advance reaches end of row
    logic       last_row;   // cursor on last row
    logic       col_zero;   // cursor column is zero
    logic       walk_last;  // walk index at its last destination index
    logic       walk_fill;  // walk index in the blank fill region
    logic       walk_done;  // walk at its final write
  } stat_t;

  function automatic logic [8:0] to_screen(input logic [7:0] ch);
    logic [8:0] code;
    code = {1'b1, ch};
    if (ch == 8'h5B) begin
      code = 9'h01B;
    end else if (ch == 8'h5D) begin
      code = 9'h01D;
    end else if (ch[5] && ch[6]) begin
      code = code & 9'h19F;
    end
    return code;
  endfunction
endpackage

[hw/rtl/text_console_cursor_engine_top.sv]
`timescale 1ns / 1ps
// Cursor commands pass Disp and Finish; reads add RdDone; a stored character adds Write, AdvChk, Adv.
// Tab stores four cells. Scroll, clear and delete walk the cell
// RAM through its single read port, with a read and a write per cell.
// One item is in work at a time; the next is taken the cycle after its result is set.
// Reset (rst_ni low, async) clears cursor, registers to 32 rows, 64 cols, attr 0.
module text_console_cursor_engine_top #(
  parameter int unsigned MaxRows = tce_pkg::MaxRowsDef,
  parameter int unsigned MaxCols = tce_pkg::MaxColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  target_row_i,
  input  logic [6:0]  target_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  cursor_row_out_o,
  output logic [6:0]  cursor_col_out_o,
  output logic [12:0] cursor_index_o,
  output logic [15:0] cell_data_o
);
  tce_pkg::cmd_t  ctl;
  tce_pkg::stat_t stat;

  tce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .ctl_o(ctl), .stat_i(stat)
  );

  tce_datapath #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i, .char_code_i, .target_row_i, .target_col_i,
    .cursor_row_out_o, .cursor_col_out_o, .cursor_index_o, .cell_data_o
  );
endmodule

[hw/rtl/tce_ram.sv]
`timescale 1ns / 1ps
module tce_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/tce_datapath.sv]
`timescale 1ns / 1ps
`include "text_console_cursor_engine_top_macros.svh"
module tce_datapath #(
  parameter int unsigned MaxRows = tce_pkg::MaxRowsDef,
  parameter int unsigned MaxCols = tce_pkg::MaxColsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tce_pkg::cmd_t        ctl_i,
  output tce_pkg::stat_t       stat_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           char_code_i,
  input  logic [5:0]           target_row_i,
  input  logic [6:0]           target_col_i,
  output logic [5:0]           cursor_row_out_o,
  output logic [6:0]           cursor_col_out_o,
  output logic [12:0]          cursor_index_o,
  output logic [15:0]          cell_data_o
);
  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW = 7;  // row counts up to 64
  localparam int unsigned CW = 8;  // column counts up to 128
  localparam int unsigned RLim = (MaxRows < 64) ? MaxRows : 64;
  localparam int unsigned CLim = (MaxCols < 128) ? MaxCols : 128;

  logic [6:0]  rows_cfg_q;
  logic [7:0]  cols_cfg_q;
  logic [15:0] attr_q;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;

  logic [1:0] cmd_q;
  logic [7:0] ch_q;
  logic [5:0] tr_q;
  logic [6:0] tc_q;
  logic [5:0] row_q, row_d;
  logic [6:0] col_q, col_d;
  logic [15:0] data_q, data_d;
  logic [AW-1:0] base_q, base_d;  // row_q * cols
  logic [AW-1:0] widx_q, widx_d;  // walk destination index
  logic [AW-1:0] wend_q, wend_d;  // last destination index
  logic [AW-1:0] wcopy_q, wcopy_d; // first index filled with blanks
  logic [5:0]  orow_q;
  logic [6:0]  ocol_q;
  logic [12:0] oidx_q;
  logic [15:0] odata_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [15:0]   blank;
  logic [13:0]   tprod;

  always_comb begin
    rows = (rows_cfg_q == 7'd0) ? RW'(1) :
           (32'(rows_cfg_q) > RLim) ? RW'(RLim) : RW'(rows_cfg_q);
    cols = (cols_cfg_q == 8'd0) ? CW'(1) :
           (32'(cols_cfg_q) > CLim) ? CW'(CLim) : CW'(cols_cfg_q);
  end

  assign blank = attr_q | 16'(tce_pkg::to_screen(tce_pkg::ChSpace));
  assign tprod = 14'(tr_q) * 14'(cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 7'd32;
      cols_cfg_q <= 8'd64;
      attr_q     <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tce_pkg::CfgRows: rows_cfg_q <= cfg_data_i[6:0];
        tce_pkg::CfgCols: cols_cfg_q <= cfg_data_i[7:0];
        tce_pkg::CfgAttr: attr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    row_d = row_q; col_d = col_q; data_d = data_q; base_d = base_q;
    widx_d = widx_q; wend_d = wend_q; wcopy_d = wcopy_q;
    we = 1'b0; waddr = base_q + AW'(col_q); wdata = blank;
    raddr = widx_q + AW'(1);
    case (ctl_i.op)
      tce_pkg::OpLoad: begin
        data_d = 16'd0;
        if (7'(row_q) >= rows) row_d = 6'(rows - RW'(1));
        if (8'(col_q) >= cols) col_d = 7'(cols - CW'(1));
      end
      tce_pkg::OpWrite: begin
        we = 1'b1;
        wdata = ctl_i.blank ? blank : (attr_q | 16'(tce_pkg::to_screen(ch_q)));
      end
      tce_pkg::OpAdvance: begin
        if (8'(col_q) + 8'd1 < cols) begin
          col_d = col_q + 7'd1;
        end else begin
          col_d = 7'd0;
          if (7'(row_q) + 7'd1 < rows) row_d = row_q + 6'd1;
        end
      end
      tce_pkg::OpCtrl: begin
        case (ch_q)
          tce_pkg::ChCr: col_d = 7'd0;
          tce_pkg::ChLf, tce_pkg::ChDown:
            if (7'(row_q) + 7'd1 < rows) row_d = row_q + 6'd1;
          tce_pkg::ChRight: if (8'(col_q) + 8'd1 < cols) col_d = col_q + 7'd1;
          tce_pkg::ChUp: if (row_q != 6'd0) row_d = row_q - 6'd1;
          tce_pkg::ChLeft: if (col_q != 7'd0) col_d = col_q - 7'd1;
          tce_pkg::ChHome: begin
            if (col_q == 7'd0) row_d = 6'd0;
            col_d = 7'd0;
          end
          default: ;
        endcase
      end
      tce_pkg::OpBsLeft: col_d = col_q - 7'd1;
      tce_pkg::OpRdStart: raddr = AW'(tprod) + AW'(tc_q);
      tce_pkg::OpRdDone: begin
        if (7'(tr_q) < rows && 8'(tc_q) < cols) data_d = rdata;
      end
      tce_pkg::OpSetCur: begin
        row_d = (7'(tr_q) < rows) ? tr_q : 6'(rows - RW'(1));
        col_d = (8'(tc_q) < cols) ? tc_q : 7'(cols - CW'(1));
      end
      tce_pkg::OpSeqInit: begin
        case (ctl_i.walk)
          tce_pkg::WalkClear: begin
            widx_d = '0; wcopy_d = '0;
            wend_d = AW'(14'(rows) * 14'(cols) - 14'd1);
          end
          tce_pkg::WalkScroll: begin
            widx_d = '0;
            wend_d = AW'(14'(rows) * 14'(cols) - 14'd1);
            wcopy_d = AW'(14'(rows - RW'(1)) * 14'(cols));
          end
          default: begin
            widx_d = base_q + AW'(col_q);
            wend_d = base_q + AW'(cols) - AW'(1);
            wcopy_d = wend_d;
          end
        endcase
      end
      tce_pkg::OpSeqRead: raddr = widx_q + AW'(cols);
      tce_pkg::OpSeqWrite: begin
        we = 1'b1; waddr = widx_q;
        wdata = (widx_q >= wcopy_q) ? blank : rdata;
        widx_d = widx_q + AW'(1);
      end
      default: ;
    endcase
    // delete reads the next cell, scroll reads one row below
    if (ctl_i.op == tce_pkg::OpSeqRead && ctl_i.walk == tce_pkg::WalkDelete)
      raddr = widx_q + AW'(1);
    if (row_d != row_q || ctl_i.op == tce_pkg::OpLoad || ctl_i.op == tce_pkg::OpSetCur)
      base_d = AW'(14'(row_d) * 14'(cols));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      base_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    widx_q <= widx_d;
    wend_q <= wend_d;
    wcopy_q <= wcopy_d;
    if (ctl_i.op == tce_pkg::OpLoad) begin
      cmd_q <= cmd_i; ch_q <= char_code_i; tr_q <= target_row_i; tc_q <= target_col_i;
    end
    if (ctl_i.op == tce_pkg::OpFinish) begin
      orow_q <= row_q;
      ocol_q <= col_q;
      oidx_q <= 13'(base_q + AW'(col_q));
      odata_q <= data_q;
    end
  end

  tce_ram #(.Width(tce_pkg::CellW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    stat_o.cmd = cmd_q;
    stat_o.ch = ch_q;
    stat_o.wrap = !(8'(col_q) + 8'd1 < cols);
    stat_o.last_row = !(7'(row_q) + 7'd1 < rows);
    stat_o.col_zero = (col_q == 7'd0);
    stat_o.walk_last = (widx_q == wend_q);
    stat_o.walk_fill = (widx_q >= wcopy_q);
    stat_o.walk_done = (widx_q == wend_q);
  end

  assign cursor_row_out_o = orow_q;
  assign cursor_col_out_o = ocol_q;
  assign cursor_index_o = oidx_q;
  assign cell_data_o = odata_q;

  `TCE_ASSERT(a_cur_in_range, clk_i, rst_ni,
    (ctl_i.op == tce_pkg::OpFinish) |-> (7'(row_q) < rows && 8'(col_q) < cols))
  `TCE_ASSERT(a_base_ok, clk_i, rst_ni,
    (ctl_i.op == tce_pkg::OpFinish) |-> (14'(base_q) == 14'(row_q) * 14'(cols)))
  `TCE_ASSERT(a_wr_range, clk_i, rst_ni,
    we |-> (14'(waddr) < 14'(rows) * 14'(cols)))
endmodule

[hw/rtl/tce_ctrl.sv]
`timescale 1ns / 1ps
`include "text_console_cursor_engine_top_macros.svh"
module tce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tce_pkg::cmd_t  ctl_o,
  input  tce_pkg::stat_t stat_i
);
  localparam logic [3:0] SIdle = 4'd0, SDisp = 4'd1, SWrite = 4'd2, SAdv = 4'd3,
    SRd = 4'd4, SRdDone = 4'd5, SWInit = 4'd6, SWRead = 4'd7, SWWrite = 4'd8,
    SFinish = 4'd9, SAdvChk = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] tab_q, tab_d;      // spaces still to store for a tab
  logic [1:0] walk_q, walk_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_stall_o = (state_q != SIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q; tab_d = tab_q; walk_d = walk_q;
    ovalid_d = ovalid_q && out_stall_i;
    ctl_o.op = tce_pkg::OpNone;
    ctl_o.walk = tce_pkg::walk_e'(walk_q);
    ctl_o.blank = (tab_q != 3'd0);
    case (state_q)
      SIdle: if (accept) begin
        ctl_o.op = tce_pkg::OpLoad;
        state_d = SDisp;
      end
      SDisp: begin
        tab_d = 3'd0;
        case (stat_i.cmd)
          tce_pkg::CmdPut: begin
            case (stat_i.ch)
              tce_pkg::ChCr, tce_pkg::ChRight, tce_pkg::ChUp, tce_pkg::ChLeft,
              tce_pkg::ChDown, tce_pkg::ChHome: begin
                ctl_o.op = tce_pkg::OpCtrl; state_d = SFinish;
              end
              tce_pkg::ChLf: begin
                if (stat_i.last_row) begin
                  walk_d = 2'(tce_pkg::WalkScroll); state_d = SWInit;
                end else begin
                  ctl_o.op = tce_pkg::OpCtrl; state_d = SFinish;
                end
              end
              tce_pkg::ChDel: begin
                walk_d = 2'(tce_pkg::WalkDelete); state_d = SWInit;
              end
              tce_pkg::ChBs: begin
                if (stat_i.col_zero) begin
                  state_d = SFinish;
                end else begin
                  ctl_o.op = tce_pkg::OpBsLeft;
                  walk_d = 2'(tce_pkg::WalkDelete); state_d = SWInit;
                end
              end
              tce_pkg::ChTab: begin
                tab_d = 3'd4; state_d = SWrite;
              end
              default: state_d = SWrite;
            endcase
          end
          tce_pkg::CmdRead: begin
            ctl_o.op = tce_pkg::OpRdStart; state_d = SRdDone;
          end
          tce_pkg::CmdSet: begin
            ctl_o.op = tce_pkg::OpSetCur; state_d = SFinish;
          end
          default: begin
            walk_d = 2'(tce_pkg::WalkClear); state_d = SWInit;
          end
        endcase
      end
      SWrite: begin
        ctl_o.op = tce_pkg::OpWrite; state_d = SAdvChk;
      end
      SAdvChk: begin
        // scroll needed when the store wraps off the last row
        if (stat_i.wrap && stat_i.last_row) begin
          ctl_o.op = tce_pkg::OpAdvance;
          walk_d = 2'(tce_pkg::WalkScroll); state_d = SWInit;
        end else begin
          ctl_o.op = tce_pkg::OpAdvance;
          state_d = SAdv;
        end
      end
      SAdv: begin
        if (tab_q > 3'd1) begin
          tab_d = tab_q - 3'd1; state_d = SWrite;
        end else begin
          tab_d = 3'd0; state_d = SFinish;
        end
      end
      SRd: state_d = SRdDone;
      SRdDone: begin
        ctl_o.op = tce_pkg::OpRdDone; state_d = SFinish;
      end
      SWInit: begin
        ctl_o.op = tce_pkg::OpSeqInit; state_d = SWRead;
      end
      SWRead: begin
        ctl_o.op = tce_pkg::OpSeqRead; state_d = SWWrite;
      end
      SWWrite: begin
        ctl_o.op = tce_pkg::OpSeqWrite;
        if (stat_i.walk_done) state_d = SAdv;
        else state_d = SWRead;
      end
      SFinish: begin
        if (!ovalid_d) begin
          ctl_o.op = tce_pkg::OpFinish;
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      tab_q <= '0;
      walk_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tab_q <= tab_d;
      walk_q <= walk_d;
      ovalid_q <= ovalid_d;
    end
  end

  `TCE_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q == SWWrite) |-> in_stall_o)
  `TCE_ASSERT(a_one_result, clk_i, rst_ni,
    (ctl_o.op == tce_pkg::OpFinish) |=> (out_valid_o && state_q == SIdle))
  `TCE_ASSERT(a_tab_bound, clk_i, rst_ni, tab_q <= 3'd4)
endmodule
